// ===== sv/diff_drive_odometry_defines.svh =====
// Assertion macros for the odometry block.
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`ifndef SYNTH
`define DDO_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DDO_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/ddo_pkg.sv =====
// Shared types, constants and helper functions of the odometry block.
package ddo_pkg;

    localparam int CORDIC_ITERS = 24;
    localparam int ITER_W       = 5;
    localparam int ATAN_DEPTH   = 30;

    localparam logic signed [32:0] PI_Q28         = 33'sd843314857;
    localparam logic signed [32:0] TWO_PI_Q28     = 33'sd1686629713;
    localparam logic signed [32:0] HALF_PI_Q28    = 33'sd421657428;
    localparam logic signed [31:0] QUARTER_PI_Q28 = 32'sd210828714;
    localparam logic signed [32:0] CORDIC_GAIN    = 33'sd652032874;

    localparam logic [31:0] MPT_RESET = 32'd1288490;
    localparam logic [23:0] IWB_RESET = 24'd409600;

    typedef logic signed [ATAN_DEPTH-1:0][31:0] t_atan_tab;

    typedef struct packed {
        logic load;
        logic mul_l;
        logic mul_r;
        logic turn;
        logic rot;
        logic upd_x;
        logic upd_y;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last_iter;
    } t_sts;

    // quotient of two constants by shift and subtract
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // arctangent of 2^-i in Q3.28, by odd power series in Q0.62
    function automatic logic signed [31:0] atan_q28(input int unsigned i);
        logic signed [63:0] acc;
        logic signed [63:0] tmp;
        logic [63:0] term;
        int unsigned k;
        int unsigned e;
        acc = '0;
        if (i == 0) begin
            return QUARTER_PI_Q28;
        end
        for (k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
                term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
                if (k[0]) acc = acc - signed'(term);
                else acc = acc + signed'(term);
            end
        end
        tmp = (acc + (64'sd1 <<< 33)) >>> 34;
        return tmp[31:0];
    endfunction

    function automatic t_atan_tab build_atan_tab();
        t_atan_tab tab;
        for (int i = 0; i < ATAN_DEPTH; i++) begin
            tab[i] = atan_q28(i);
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN_TAB = build_atan_tab();

    // clamp a wide signed value into signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        if (v > 67'sd2147483647) return 32'sh7fffffff;
        if (v < -67'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// ===== sv/diff_drive_odometry.sv =====
// Top level of the differential-drive odometry block.
// Input channel: i_valid with o_stall carries four encoder counts; a transfer
// happens at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid with i_stall carries pos_x, pos_y and heading.
// Configuration: APB registers metres_per_tick at 0 and inverse_wheel_base at 4.
// One update runs from input transfer to o_valid: the deltas are
// taken at the transfer, then two steps on the shared multiplier for wheel
// travel, one for distance and turn, CORDIC_ITERS (24) CORDIC rotations, two
// pose updates and one to load the output register. The next item is taken
// only once the sequencer is back in idle after the output load, so the block
// does not take a new item before it is through with the last one.
// While a result waits under i_stall a new item is still taken and worked on;
// it holds in its last step until the output register is free.
// Reset (synchronous, active low) clears pose and heading to zero, restores
// the register defaults and empties the output register.
module diff_drive_odometry (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_left_count,
    input  logic signed [31:0] i_left_prev_count,
    input  logic signed [31:0] i_right_count,
    input  logic signed [31:0] i_right_prev_count,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [30:0] o_heading,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ddo_pkg::*;

    logic [31:0] r_mpt;
    logic [23:0] r_iwb;
    logic        wr_en;
    t_cmd        cmd;
    t_sts        sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = paddr[2] ? {8'b0, r_iwb} : r_mpt;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpt <= MPT_RESET;
            r_iwb <= IWB_RESET;
        end else if (wr_en) begin
            if (paddr[2]) r_iwb <= pwdata[23:0];
            else r_mpt <= pwdata;
        end
    end

    ddo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ddo_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_mpt              (r_mpt),
        .i_iwb              (r_iwb),
        .i_left_count       (i_left_count),
        .i_left_prev_count  (i_left_prev_count),
        .i_right_count      (i_right_count),
        .i_right_prev_count (i_right_prev_count),
        .o_pos_x            (o_pos_x),
        .o_pos_y            (o_pos_y),
        .o_heading          (o_heading)
    );

`include "diff_drive_odometry_defines.svh"

    `DDO_ASSERT_NEXT(a_busy_after_take, i_valid && !o_stall, o_stall, "not busy after transfer")
    `DDO_ASSERT_IMPLIES(a_heading_range, o_valid, (o_heading <= 31'sd843314857) && (o_heading >= -31'sd843314857), "heading out of range")
    `DDO_ASSERT_NEXT(a_load_free, cmd.out_load, o_valid, "result load lost")

endmodule

// ===== sv/ddo_ctrl.sv =====
// Sequencer of the odometry block: steps the datapath through one update.
module ddo_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ddo_pkg::t_cmd o_cmd,
    input  ddo_pkg::t_sts i_sts
);
    import ddo_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL_L = 8'b0000_0010,
        S_MUL_R = 8'b0000_0100,
        S_TURN  = 8'b0000_1000,
        S_ROT   = 8'b0001_0000,
        S_UPD_X = 8'b0010_0000,
        S_UPD_Y = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   out_free;

    assign out_free    = !(r_valid && i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_valid;

    // decode state into datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_valid;
        o_cmd.mul_l    = (r_state == S_MUL_L);
        o_cmd.mul_r    = (r_state == S_MUL_R);
        o_cmd.turn     = (r_state == S_TURN);
        o_cmd.rot      = (r_state == S_ROT);
        o_cmd.upd_x    = (r_state == S_UPD_X);
        o_cmd.upd_y    = (r_state == S_UPD_Y);
        o_cmd.out_load = (r_state == S_DONE) && out_free;
    end

    // advance through the update sequence
    always_comb begin
        n_state = r_state;
        n_valid = r_valid && i_out_stall;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_MUL_L;
            S_MUL_L: n_state = S_MUL_R;
            S_MUL_R: n_state = S_TURN;
            S_TURN:  n_state = S_ROT;
            S_ROT:   if (i_sts.last_iter) n_state = S_UPD_X;
            S_UPD_X: n_state = S_UPD_Y;
            S_UPD_Y: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

// ===== sv/ddo_datapath.sv =====
// Datapath of the odometry block: shared multiplier, CORDIC and pose registers.
module ddo_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ddo_pkg::t_cmd       i_cmd,
    output ddo_pkg::t_sts       o_sts,
    input  logic [31:0]         i_mpt,
    input  logic [23:0]         i_iwb,
    input  logic signed [31:0]  i_left_count,
    input  logic signed [31:0]  i_left_prev_count,
    input  logic signed [31:0]  i_right_count,
    input  logic signed [31:0]  i_right_prev_count,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [30:0]  o_heading
);
    import ddo_pkg::*;

    logic signed [31:0] r_dl, r_dr, r_tl, r_tr, r_dist, r_dth;
    logic signed [32:0] r_cx, r_cy, r_cz;
    logic               r_flip;
    logic [ITER_W-1:0]  r_iter;
    logic signed [31:0] r_x, r_y, r_th;
    logic signed [31:0] r_out_x, r_out_y;
    logic signed [30:0] r_out_th;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic signed [32:0] sum_t, diff_t, th_ext, th_sum;
    logic signed [65:0] dth_w;
    logic signed [32:0] xs, ys, atan_a;
    logic signed [66:0] acc_sum;

    assign o_sts.last_iter = (r_iter == ITER_W'(CORDIC_ITERS - 1));

    assign sum_t  = 33'(r_tl) + 33'(r_tr);
    assign diff_t = 33'(r_tr) - 33'(r_tl);
    assign th_ext = 33'(r_th);

    // select operands of the shared multiplier
    always_comb begin
        mul_a = 33'(r_dl);
        mul_b = signed'({1'b0, i_mpt});
        if (i_cmd.mul_r) begin
            mul_a = 33'(r_dr);
        end else if (i_cmd.turn) begin
            mul_a = diff_t;
            mul_b = signed'({9'b0, i_iwb});
        end else if (i_cmd.upd_x) begin
            mul_a = 33'(r_dist);
            mul_b = r_flip ? -r_cx : r_cx;
        end else if (i_cmd.upd_y) begin
            mul_a = 33'(r_dist);
            mul_b = r_flip ? -r_cy : r_cy;
        end
    end

    assign prod    = 66'(mul_a) * 66'(mul_b);
    assign dth_w   = prod >>> 4;
    assign acc_sum = i_cmd.upd_x ? (67'(r_x) + 67'(prod >>> 30))
                                 : (67'(r_y) + 67'(prod >>> 30));
    assign th_sum  = th_ext + 33'(r_dth);

    assign xs     = r_cx >>> r_iter;
    assign ys     = r_cy >>> r_iter;
    assign atan_a = 33'(ATAN_TAB[r_iter]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x  <= '0;
            r_y  <= '0;
            r_th <= '0;
        end else begin
            if (i_cmd.upd_x) r_x <= sat32(acc_sum);
            if (i_cmd.upd_y) begin
                r_y <= sat32(acc_sum);
                // take the turn and wrap once into [-pi, pi]
                if (th_sum < -PI_Q28) r_th <= 32'(th_sum + TWO_PI_Q28);
                else if (th_sum > PI_Q28) r_th <= 32'(th_sum - TWO_PI_Q28);
                else r_th <= th_sum[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // latch tick deltas with 32-bit wrap
        if (i_cmd.load) begin
            r_dl <= i_left_count - i_left_prev_count;
            r_dr <= i_right_count - i_right_prev_count;
        end
        if (i_cmd.mul_l) r_tl <= sat32(67'(prod >>> 16));
        if (i_cmd.mul_r) r_tr <= sat32(67'(prod >>> 16));
        // distance, clamped turn and CORDIC start
        if (i_cmd.turn) begin
            r_dist <= sum_t[32:1];
            if (dth_w > 66'(PI_Q28)) r_dth <= 32'(PI_Q28);
            else if (dth_w < -66'(PI_Q28)) r_dth <= 32'(-PI_Q28);
            else r_dth <= dth_w[31:0];
            r_cx   <= CORDIC_GAIN;
            r_cy   <= '0;
            r_iter <= '0;
            if (th_ext > HALF_PI_Q28) begin
                r_cz   <= th_ext - PI_Q28;
                r_flip <= 1'b1;
            end else if (th_ext < -HALF_PI_Q28) begin
                r_cz   <= th_ext + PI_Q28;
                r_flip <= 1'b1;
            end else begin
                r_cz   <= th_ext;
                r_flip <= 1'b0;
            end
        end
        // one CORDIC rotation per cycle
        if (i_cmd.rot) begin
            r_iter <= r_iter + 1'b1;
            if (!r_cz[32]) begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - atan_a;
            end else begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + atan_a;
            end
        end
        if (i_cmd.out_load) begin
            r_out_x  <= r_x;
            r_out_y  <= r_y;
            r_out_th <= r_th[30:0];
        end
    end

    assign o_pos_x   = r_out_x;
    assign o_pos_y   = r_out_y;
    assign o_heading = r_out_th;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the differential-drive odometry block: directed and random updates.
module tb_top;
    import ddo_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_left_count;
    logic signed [31:0] i_left_prev_count;
    logic signed [31:0] i_right_count;
    logic signed [31:0] i_right_prev_count;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic signed [30:0] o_heading;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    localparam logic [2:0] ADDR_MPT = 3'd0;
    localparam logic [2:0] ADDR_IWB = 3'd4;
    localparam int         HOLD_CYCLES = 300;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [30:0] heading;
    } t_pose;

    t_pose pose_q[$];
    int    n_fail;
    bit    rx_idle_en;
    bit    hold_go;
    int    hold_cnt = 0;

    // predictor state
    logic [31:0]        m_mpt;
    logic [23:0]        m_iwb;
    logic signed [31:0] m_x;
    logic signed [31:0] m_y;
    logic signed [31:0] m_th;
    longint             atan_lut[30];

    diff_drive_odometry i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // arctangent of 2^-i in Q3.28 from the odd power series
    function automatic longint calc_atan(int i);
        longint acc;
        longint term;
        acc = 0;
        if (i == 0) return 64'sd210828714;
        for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
            term = longint'((64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1));
            acc = (k % 2) ? acc - term : acc + term;
        end
        return (acc + (64'sd1 <<< 33)) >>> 34;
    endfunction

    function automatic longint travel(logic [31:0] cur, logic [31:0] prev);
        logic signed [31:0] d;
        d = cur - prev;
        return clamp32(floor_shift(longint'(d) * longint'({32'd0, m_mpt}), 16));
    endfunction

    // advance the pose by one update and queue the result
    task automatic predict_pose(logic [31:0] lc, logic [31:0] lp,
                                logic [31:0] rc, logic [31:0] rp);
        longint tl, tr, fwd, dth, cx, sy, z, xs, ys, th;
        bit     flip;
        t_pose  p;
        tl = travel(lc, lp);
        tr = travel(rc, rp);
        fwd = floor_shift(tl + tr, 1);
        dth = floor_shift((tr - tl) * longint'({40'd0, m_iwb}), 4);
        if (dth > 843314857) dth = 843314857;
        else if (dth < -843314857) dth = -843314857;
        cx = 652032874; sy = 0; z = m_th; flip = 0;
        if (z > 421657428) begin z -= 843314857; flip = 1; end
        else if (z < -421657428) begin z += 843314857; flip = 1; end
        for (int i = 0; i < CORDIC_ITERS && i < 30; i++) begin
            xs = floor_shift(cx, i);
            ys = floor_shift(sy, i);
            if (z >= 0) begin cx -= ys; sy += xs; z -= atan_lut[i]; end
            else begin cx += ys; sy -= xs; z += atan_lut[i]; end
        end
        if (flip) begin cx = -cx; sy = -sy; end
        m_x = 32'(clamp32(longint'(m_x) + floor_shift(fwd * cx, 30)));
        m_y = 32'(clamp32(longint'(m_y) + floor_shift(fwd * sy, 30)));
        th = longint'(m_th) + dth;
        if (th < -843314857) th += 1686629713;
        else if (th > 843314857) th -= 1686629713;
        m_th = 32'(th);
        p.pos_x = m_x; p.pos_y = m_y; p.heading = m_th[30:0];
        pose_q.push_back(p);
    endtask

    // one transfer on the input channel, with random gaps when gaps is set
    task automatic send_counts(logic [31:0] lc, logic [31:0] lp,
                               logic [31:0] rc, logic [31:0] rp, bit gaps);
        @(negedge i_clk);
        while (gaps && $urandom_range(99) < 29) @(negedge i_clk);
        i_valid <= 1'b1;
        i_left_count <= lc; i_left_prev_count <= lp;
        i_right_count <= rc; i_right_prev_count <= rp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_pose(lc, lp, rc, rp);
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_MPT) m_mpt = data;
        else m_iwb = data[23:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // drain outstanding results before touching the registers
    task automatic wait_drained();
        while (pose_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] mpt, logic [31:0] iwb);
        wait_drained();
        apb_write(ADDR_MPT, mpt);
        apb_write(ADDR_IWB, iwb);
    endtask

    function automatic logic [31:0] rnd_count();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'h7fffffff ^ $urandom_range(3);
            2: return 32'h80000000 + $urandom_range(3);
            default: return 32'($urandom_range(2000)) - 32'd1000;
        endcase
    endfunction

    task automatic test_extremes();
        send_counts(0, 0, 0, 0, 0);
        send_counts(1000, 0, 1000, 0, 0);
        send_counts(0, 1000, 1000, 0, 0);
        send_counts(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0);
        send_counts(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0);
        send_counts(32'hffffffff, 32'hffffffff, 32'h00000001, 32'hffffffff, 0);
        // turn past pi/2 so the shifted-angle path is used
        repeat (4) send_counts(0, 5000, 5000, 0, 0);
        repeat (3) send_counts(3000, 0, 3000, 0, 0);
        repeat (3) send_counts(5000, 0, 0, 5000, 0);
    endtask

    task automatic test_huge_travel();
        set_regs(32'hffffffff, 24'hffffff);
        send_counts(32'h7fffffff, 0, 32'h7fffffff, 0, 0);
        send_counts(32'h80000000, 0, 32'h7fffffff, 0, 0);
        // drive the position into saturation both ways
        repeat (4) send_counts(32'h7fffffff, 0, 32'h7fffffff, 0, 0);
        repeat (4) send_counts(32'h80000000, 0, 32'h80000000, 0, 0);
        set_regs(32'd1, 24'd1);
        send_counts(32'h12345678, 0, 32'h76543210, 0, 0);
    endtask

    task automatic test_random(int n);
        logic [31:0] lp, rp, lc, rc;
        for (int k = 0; k < n; k++) begin
            if (k % 100 == 0) begin
                case ($urandom_range(3))
                    0: set_regs(MPT_RESET, IWB_RESET);
                    1: set_regs($urandom(), $urandom_range(24'hffffff, 1));
                    2: set_regs($urandom_range(5000000, 1), $urandom_range(2000000, 1));
                    default: set_regs(32'hffffffff, 24'hffffff);
                endcase
            end
            if ($urandom_range(3) == 0) begin
                lc = rnd_count(); lp = rnd_count(); rc = rnd_count(); rp = rnd_count();
            end else begin
                lp = $urandom(); rp = $urandom();
                lc = lp + 32'($urandom_range(4000)) - 32'd2000;
                rc = rp + 32'($urandom_range(4000)) - 32'd2000;
            end
            send_counts(lc, lp, rc, rp, !(k >= 300 && k < 400));
        end
    endtask

    // hold the receiver off while items keep coming
    task automatic test_backpressure();
        hold_go = 1'b1;
        for (int k = 0; k < 12; k++)
            send_counts($urandom(), $urandom(), $urandom(), $urandom(), 0);
    endtask

    // receiver stall generation
    always @(negedge i_clk) begin
        if (hold_go && hold_cnt < HOLD_CYCLES) begin
            i_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_stall <= rx_idle_en && ($urandom_range(99) < 29);
        end
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_pose want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pose_q.size() == 0) begin
                $error("unexpected result x=%0d y=%0d h=%0d", o_pos_x, o_pos_y, o_heading);
                n_fail++;
            end else begin
                want = pose_q.pop_front();
                if (o_pos_x !== want.pos_x) begin
                    $error("pos_x expected %0d actual %0d", want.pos_x, o_pos_x);
                    n_fail++;
                end
                if (o_pos_y !== want.pos_y) begin
                    $error("pos_y expected %0d actual %0d", want.pos_y, o_pos_y);
                    n_fail++;
                end
                if (o_heading !== want.heading) begin
                    $error("heading expected %0d actual %0d", want.heading, o_heading);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_clk = 1'b0; i_rst_n = 1'b0; i_valid = 1'b0;
        i_left_count = '0; i_left_prev_count = '0;
        i_right_count = '0; i_right_prev_count = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        n_fail = 0; rx_idle_en = 1'b0; hold_go = 1'b0;
        for (int i = 0; i < 30; i++) atan_lut[i] = calc_atan(i);
        m_mpt = MPT_RESET; m_iwb = IWB_RESET; m_x = 0; m_y = 0; m_th = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_huge_travel();
        rx_idle_en = 1'b1;
        test_backpressure();
        test_random(820);
        wait_drained();
        if (n_fail == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== diff_drive_odometry.f =====
+incdir+sv
sv/ddo_pkg.sv
sv/ddo_ctrl.sv
sv/ddo_datapath.sv
sv/diff_drive_odometry.sv
bench/tb_top.sv
